// ===== rtl/core/mld_pkg.sv =====
// shared types and constants for the line diff block
// no dependencies; imported by the controller, datapath and top level
package mld_pkg;

    localparam int MAX_LINES   = 32;
    localparam int KEY_BITS    = 32;
    localparam int IDX_W       = $clog2(MAX_LINES);
    localparam int CNT_W       = $clog2(MAX_LINES + 1);
    localparam int MAXD        = 2 * MAX_LINES;
    localparam int D_W         = $clog2(MAXD + 1);
    localparam int POS_W       = 8;
    localparam int KOFS        = MAXD;
    localparam int ROW_LEN     = 2 * MAXD + 1;
    localparam int TRACE_DEPTH = (MAXD + 1) * ROW_LEN;
    localparam int TRACE_AW    = $clog2(TRACE_DEPTH);
    localparam int SB_DEPTH    = MAXD;
    localparam int SB_AW       = $clog2(SB_DEPTH);
    localparam int SB_CW       = $clog2(SB_DEPTH + 1);

    localparam logic [1:0] KIND_LEFT  = 2'd0;
    localparam logic [1:0] KIND_RIGHT = 2'd1;
    localparam logic [1:0] KIND_RUN   = 2'd2;

    localparam logic [1:0] OP_EQUAL  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EMPTY,
        S_F_READ,
        S_F_PICK,
        S_F_SNAKE,
        S_B_TOP,
        S_B_READ,
        S_B_PICK,
        S_B_SNAKE,
        S_TAIL,
        S_E_READ,
        S_E_LOAD
    } state_t;

    typedef struct packed {
        logic load_left;
        logic load_right;
        logic fwd_init;
        logic rd_issue;
        logic fwd_pick;
        logic snake_step;
        logic fwd_write;
        logic bk_setk;
        logic bk_pick;
        logic bk_eq;
        logic bk_edge;
        logic tail_step;
        logic emit_issue;
        logic out_load;
        logic out_none;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic both_empty;
        logic snake_match;
        logic fwd_done;
        logic d_zero;
        logic bk_more;
        logic tail_any;
        logic sb_empty;
        logic emit_last;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/myers_line_diff.sv =====
// line diff engine: shortest edit script over two loaded key sequences
// instantiates mld_ctrl and mld_dp; depends on mld_pkg
//
// input channel (in_valid/in_stall, kind, key): kind 0 appends a left key,
// kind 1 a right key, kind 2 runs the diff; kind 3 is taken and ignored.
// up to 32 keys per side are stored; extra keys are dropped
// and reported as overflow on every word of the next run.
// a run searches diagonal by diagonal (trace read, pick, compare) with a
// step per snake move, then backtracks round by round (set diagonal,
// trace read, pick) with a step per script op, and emits each op by a
// script buffer read and an output load.
// output channel (out_valid/out_stall, op, left_index, right_index, last,
// overflow) is a single register; a stall holds the word and pauses the
// emission sequencer. in_stall is high from a run until its last word is
// loaded. both sides empty gives one word with op none.
// reset clears the counts, overflow flag, sequencer and output valid.
module myers_line_diff
    import mld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  op,
    output logic [4:0]  left_index,
    output logic [4:0]  right_index,
    output logic        last,
    output logic        overflow
);

    cmd_t  cmd;
    stat_t stat;

    mld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    mld_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .key         (key),
        .out_stall   (out_stall),
        .stat        (stat),
        .out_valid   (out_valid),
        .op          (op),
        .left_index  (left_index),
        .right_index (right_index),
        .last        (last),
        .overflow    (overflow)
    );

endmodule

// ===== rtl/core/mld_ctrl.sv =====
// sequencer for load, forward search, backtrack and script output
// depends on mld_pkg for state, command and status types
module mld_ctrl
    import mld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] kind,
    input  stat_t      stat,
    output logic       in_stall,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && kind == KIND_RUN)
                begin
                    state_next = stat.both_empty ? S_EMPTY : S_F_READ;
                end
            end
            S_EMPTY:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_F_READ:  state_next = S_F_PICK;
            S_F_PICK:  state_next = S_F_SNAKE;
            S_F_SNAKE:
            begin
                if (!stat.snake_match)
                begin
                    state_next = stat.fwd_done ? S_B_TOP : S_F_READ;
                end
            end
            S_B_TOP:   state_next = stat.d_zero ? S_TAIL : S_B_READ;
            S_B_READ:  state_next = S_B_PICK;
            S_B_PICK:  state_next = S_B_SNAKE;
            S_B_SNAKE:
            begin
                if (!stat.bk_more)
                begin
                    state_next = S_B_TOP;
                end
            end
            S_TAIL:
            begin
                if (!stat.tail_any)
                begin
                    state_next = stat.sb_empty ? S_IDLE : S_E_READ;
                end
            end
            S_E_READ:  state_next = S_E_LOAD;
            S_E_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.emit_last ? S_IDLE : S_E_READ;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_left  = in_valid && kind == KIND_LEFT;
                cmd.load_right = in_valid && kind == KIND_RIGHT;
                cmd.fwd_init   = in_valid && kind == KIND_RUN && !stat.both_empty;
            end
            S_EMPTY:
            begin
                cmd.out_load = stat.out_free;
                cmd.out_none = 1'b1;
                cmd.finish   = stat.out_free;
            end
            S_F_READ:  cmd.rd_issue = 1'b1;
            S_F_PICK:  cmd.fwd_pick = 1'b1;
            S_F_SNAKE:
            begin
                cmd.snake_step = stat.snake_match;
                cmd.fwd_write  = !stat.snake_match;
            end
            S_B_TOP:   cmd.bk_setk = !stat.d_zero;
            S_B_READ:  cmd.rd_issue = 1'b1;
            S_B_PICK:  cmd.bk_pick = 1'b1;
            S_B_SNAKE:
            begin
                cmd.bk_eq   = stat.bk_more;
                cmd.bk_edge = !stat.bk_more;
            end
            S_TAIL:
            begin
                cmd.tail_step = stat.tail_any;
                cmd.finish    = !stat.tail_any && stat.sb_empty;
            end
            S_E_READ:  cmd.emit_issue = 1'b1;
            S_E_LOAD:
            begin
                cmd.out_load = stat.out_free;
                cmd.finish   = stat.out_free && stat.emit_last;
            end
            default:   cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/mld_dp.sv =====
// key stores, frontier trace memory, script buffer and output register
// depends on mld_pkg; driven by mld_ctrl commands
module mld_dp
    import mld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic [31:0] key,
    input  logic        out_stall,
    output stat_t       stat,
    output logic        out_valid,
    output logic [1:0]  op,
    output logic [4:0]  left_index,
    output logic [4:0]  right_index,
    output logic        last,
    output logic        overflow
);

    logic [KEY_BITS-1:0]     left_mem  [MAX_LINES];
    logic [KEY_BITS-1:0]     right_mem [MAX_LINES];
    logic [POS_W-1:0]        trace_mem [TRACE_DEPTH];
    logic [11:0]             sb_mem    [SB_DEPTH];

    logic [CNT_W-1:0]        n_reg;
    logic [CNT_W-1:0]        m_reg;
    logic                    dropped_reg;
    logic signed [POS_W-1:0] x_reg;
    logic signed [POS_W-1:0] y_reg;
    logic signed [POS_W-1:0] k_reg;
    logic signed [POS_W-1:0] px_reg;
    logic signed [POS_W-1:0] py_reg;
    logic [D_W-1:0]          d_reg;
    logic [SB_CW-1:0]        cnt_reg;
    logic [SB_CW-1:0]        e_reg;
    logic signed [POS_W-1:0] rd_lo_reg;
    logic signed [POS_W-1:0] rd_hi_reg;
    logic [11:0]             sb_rd_reg;
    logic [KEY_BITS-1:0]     lk_reg;
    logic [KEY_BITS-1:0]     rk_reg;
    logic                    out_valid_reg;
    logic [1:0]              op_reg;
    logic [4:0]              li_reg;
    logic [4:0]              ri_reg;
    logic                    last_reg;
    logic                    ovf_reg;

    logic [D_W-1:0]          r_prev;
    logic [POS_W-1:0]        kidx;
    logic [TRACE_AW-1:0]     addr_lo;
    logic [TRACE_AW-1:0]     addr_hi;
    logic [TRACE_AW-1:0]     addr_wr;
    logic signed [POS_W-1:0] dk;
    logic signed [POS_W-1:0] hi_eff;
    logic                    take_up;
    logic signed [POS_W-1:0] pick_x;
    logic signed [POS_W-1:0] pick_y;
    logic signed [POS_W-1:0] pick_pk;
    logic signed [POS_W-1:0] n_s;
    logic signed [POS_W-1:0] m_s;
    logic signed [POS_W-1:0] x_dec;
    logic signed [POS_W-1:0] y_dec;
    logic signed [POS_W-1:0] x_inc;
    logic signed [POS_W-1:0] y_inc;
    logic                    found_now;
    logic                    push_en;
    logic [11:0]             push_word;
    logic [SB_AW-1:0]        emit_addr;

    function automatic logic [TRACE_AW-1:0] taddr(input logic [D_W-1:0] r,
                                                  input logic [POS_W-1:0] ki);
        // row * ROW_LEN, row length being 2^(D_W) + 1
        taddr = TRACE_AW'({r, {(D_W){1'b0}}}) + TRACE_AW'(r) + TRACE_AW'(ki);
    endfunction

    assign r_prev  = d_reg - D_W'(1);
    assign kidx    = POS_W'(k_reg + POS_W'(KOFS));
    assign addr_lo = taddr(r_prev, kidx - POS_W'(1));
    assign addr_hi = taddr(r_prev, kidx + POS_W'(1));
    assign addr_wr = taddr(d_reg, kidx);
    assign dk      = $signed(POS_W'(d_reg));
    assign hi_eff  = (d_reg == '0) ? '0 : rd_hi_reg;
    assign take_up = (k_reg == -dk) || (k_reg != dk && rd_lo_reg < hi_eff);
    assign pick_x  = take_up ? hi_eff : rd_lo_reg + POS_W'(1);
    assign pick_y  = pick_x - k_reg;
    assign pick_pk = take_up ? k_reg + POS_W'(1) : k_reg - POS_W'(1);
    assign n_s     = $signed(POS_W'(n_reg));
    assign m_s     = $signed(POS_W'(m_reg));
    assign x_dec   = x_reg - POS_W'(1);
    assign y_dec   = y_reg - POS_W'(1);
    assign x_inc   = x_reg + POS_W'(1);
    assign y_inc   = y_reg + POS_W'(1);
    assign found_now = (x_reg >= n_s) && (y_reg >= m_s);
    assign emit_addr = SB_AW'(cnt_reg - e_reg - SB_CW'(1));

    always_comb
    begin
        stat.both_empty  = (n_reg == '0) && (m_reg == '0);
        stat.snake_match = (x_reg >= 0) && (y_reg >= 0) && (x_reg < n_s) && (y_reg < m_s)
                           && (lk_reg == rk_reg);
        stat.fwd_done    = found_now || (k_reg == dk && d_reg == D_W'(n_reg) + D_W'(m_reg));
        stat.d_zero      = (d_reg == '0);
        stat.bk_more     = (x_reg > px_reg) && (y_reg > py_reg);
        stat.tail_any    = (x_reg > 0) || (y_reg > 0);
        stat.sb_empty    = (cnt_reg == '0);
        stat.emit_last   = (e_reg == cnt_reg - SB_CW'(1));
        stat.out_free    = !out_valid_reg || !out_stall;
    end

    // one script word per push, ops gathered back to front
    always_comb
    begin
        push_en   = 1'b0;
        push_word = '0;
        if (cmd.bk_eq)
        begin
            push_en   = 1'b1;
            push_word = {OP_EQUAL, x_dec[4:0], y_dec[4:0]};
        end
        else if (cmd.bk_edge)
        begin
            push_en   = 1'b1;
            push_word = (x_reg == px_reg) ? {OP_INSERT, 5'd0, y_dec[4:0]}
                                          : {OP_DELETE, x_dec[4:0], 5'd0};
        end
        else if (cmd.tail_step)
        begin
            push_en = 1'b1;
            priority if (x_reg > 0 && y_reg > 0)
                push_word = {OP_EQUAL, x_dec[4:0], y_dec[4:0]};
            else if (x_reg > 0)
                push_word = {OP_DELETE, x_dec[4:0], 5'd0};
            else
                push_word = {OP_INSERT, 5'd0, y_dec[4:0]};
        end
    end

    // memories: no reset, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.load_left && n_reg < CNT_W'(MAX_LINES))
        begin
            left_mem[n_reg[IDX_W-1:0]] <= key[KEY_BITS-1:0];
        end
        if (cmd.load_right && m_reg < CNT_W'(MAX_LINES))
        begin
            right_mem[m_reg[IDX_W-1:0]] <= key[KEY_BITS-1:0];
        end
        // keys at the next snake position, fetched as the position moves
        if (cmd.fwd_pick)
        begin
            lk_reg <= left_mem[pick_x[IDX_W-1:0]];
            rk_reg <= right_mem[pick_y[IDX_W-1:0]];
        end
        else if (cmd.snake_step)
        begin
            lk_reg <= left_mem[x_inc[IDX_W-1:0]];
            rk_reg <= right_mem[y_inc[IDX_W-1:0]];
        end
        if (cmd.fwd_write)
        begin
            trace_mem[addr_wr] <= x_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_lo_reg <= trace_mem[addr_lo];
            rd_hi_reg <= trace_mem[addr_hi];
        end
        if (push_en && cnt_reg < SB_CW'(SB_DEPTH))
        begin
            sb_mem[cnt_reg[SB_AW-1:0]] <= push_word;
        end
        if (cmd.emit_issue)
        begin
            sb_rd_reg <= sb_mem[emit_addr];
        end
    end

    // search and backtrack position registers, script counts and output word
    always_ff @(posedge clk)
    begin
        if (cmd.fwd_init)
        begin
            d_reg   <= '0;
            k_reg   <= '0;
            e_reg   <= '0;
            cnt_reg <= '0;
        end
        if (cmd.fwd_pick)
        begin
            x_reg <= pick_x;
            y_reg <= pick_y;
        end
        if (cmd.snake_step)
        begin
            x_reg <= x_inc;
            y_reg <= y_inc;
        end
        if (cmd.fwd_write)
        begin
            if (found_now)
            begin
                x_reg <= x_reg;
            end
            else if (k_reg == dk)
            begin
                if (stat.fwd_done)
                begin
                    // search exhausted without reaching the corner
                    x_reg <= '0;
                    y_reg <= '0;
                end
                else
                begin
                    d_reg <= d_reg + D_W'(1);
                    k_reg <= -(dk + POS_W'(1));
                end
            end
            else
            begin
                k_reg <= k_reg + POS_W'(2);
            end
        end
        if (cmd.bk_setk)
        begin
            k_reg <= x_reg - y_reg;
        end
        if (cmd.bk_pick)
        begin
            px_reg <= pick_x - (take_up ? POS_W'(0) : POS_W'(1));
            py_reg <= pick_x - (take_up ? POS_W'(0) : POS_W'(1)) - pick_pk;
        end
        if (cmd.bk_eq)
        begin
            x_reg <= x_dec;
            y_reg <= y_dec;
        end
        if (cmd.bk_edge)
        begin
            if (x_reg == px_reg)
                y_reg <= y_dec;
            else
                x_reg <= x_dec;
            d_reg <= d_reg - D_W'(1);
        end
        if (cmd.tail_step)
        begin
            if (x_reg > 0)
                x_reg <= x_dec;
            if (y_reg > 0 && (x_reg == 0 || x_reg > 0))
                y_reg <= (x_reg > 0 && y_reg > 0) || x_reg <= 0 ? y_dec : y_reg;
        end
        if (push_en && cnt_reg < SB_CW'(SB_DEPTH))
        begin
            cnt_reg <= cnt_reg + SB_CW'(1);
        end
        if (cmd.out_load && !cmd.out_none)
        begin
            e_reg <= e_reg + SB_CW'(1);
        end
        if (cmd.out_load)
        begin
            op_reg   <= cmd.out_none ? OP_NONE : sb_rd_reg[11:10];
            li_reg   <= cmd.out_none ? 5'd0 : sb_rd_reg[9:5];
            ri_reg   <= cmd.out_none ? 5'd0 : sb_rd_reg[4:0];
            last_reg <= cmd.out_none ? 1'b1 : stat.emit_last;
            ovf_reg  <= dropped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            m_reg         <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                n_reg       <= '0;
                m_reg       <= '0;
                dropped_reg <= 1'b0;
            end
            else
            begin
                if (cmd.load_left)
                begin
                    if (n_reg < CNT_W'(MAX_LINES))
                        n_reg <= n_reg + CNT_W'(1);
                    else
                        dropped_reg <= 1'b1;
                end
                if (cmd.load_right)
                begin
                    if (m_reg < CNT_W'(MAX_LINES))
                        m_reg <= m_reg + CNT_W'(1);
                    else
                        dropped_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign op          = op_reg;
    assign left_index  = li_reg;
    assign right_index = ri_reg;
    assign last        = last_reg;
    assign overflow    = ovf_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        push_en |-> (cnt_reg < SB_CW'(SB_DEPTH)))
        else $error("script count past buffer depth");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("output word overwritten while stalled");

    a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fwd_write |-> (d_reg <= D_W'(MAXD)))
        else $error("search round beyond limit");

endmodule

// ===== test/myers_line_diff_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for myers_line_diff: loads key sequences, runs diffs
// and checks the emitted edit script against a behavioral predictor; uses mld_pkg
module myers_line_diff_tb;
    import mld_pkg::*;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] li;
        logic [4:0] ri;
        logic       lst;
        logic       ovf;
    } edit_word_t;

    class edit_scoreboard;
        edit_word_t pending[$];
        logic [31:0] left_keys[MAX_LINES];
        logic [31:0] right_keys[MAX_LINES];
        int n_left;
        int n_right;
        bit dropped;
        int errors;
        int words_seen;
        int runs_seen;

        function new();
            n_left = 0;
            n_right = 0;
            dropped = 0;
            errors = 0;
            words_seen = 0;
            runs_seen = 0;
        endfunction

        // greedy shortest-edit search, then backtrack into forward script
        function void predict_script();
            int front[2*MAXD+3];
            int trace[MAXD+1][2*MAXD+3];
            edit_word_t fwd[$];
            edit_word_t w;
            int rows, ex, ey, x, y, k, d, px, py, pk;
            bit found;
            rows = 0; ex = 0; ey = 0; found = 0;
            for (int i = 0; i < 2*MAXD+3; i++) front[i] = -1;
            front[MAXD+2] = 0;
            for (d = 0; d <= n_left + n_right && !found; d++)
            begin
                for (k = -d; k <= d; k += 2)
                begin
                    if (k == -d || (k != d && front[MAXD+1+k-1] < front[MAXD+1+k+1]))
                        x = front[MAXD+1+k+1];
                    else
                        x = front[MAXD+1+k-1] + 1;
                    y = x - k;
                    while (x >= 0 && y >= 0 && x < n_left && y < n_right
                           && left_keys[x] == right_keys[y])
                    begin
                        x++;
                        y++;
                    end
                    front[MAXD+1+k] = x;
                    if (x >= n_left && y >= n_right)
                    begin
                        ex = x; ey = y; found = 1;
                        break;
                    end
                end
                trace[rows] = front;
                rows++;
            end
            x = ex; y = ey;
            w.ovf = dropped;
            w.lst = 0;
            // ops come out back to front, so each goes to the head
            for (d = rows - 1; d > 0; d--)
            begin
                k = x - y;
                if (k == -d || (k != d && trace[d-1][MAXD+1+k-1] < trace[d-1][MAXD+1+k+1]))
                    pk = k + 1;
                else
                    pk = k - 1;
                px = trace[d-1][MAXD+1+pk];
                py = px - pk;
                while (x > px && y > py)
                begin
                    w.op = OP_EQUAL; w.li = 5'(x - 1); w.ri = 5'(y - 1); fwd.push_front(w);
                    x--; y--;
                end
                if (x == px)
                begin
                    w.op = OP_INSERT; w.li = 5'd0; w.ri = 5'(y - 1); fwd.push_front(w);
                    y--;
                end
                else
                begin
                    w.op = OP_DELETE; w.li = 5'(x - 1); w.ri = 5'd0; fwd.push_front(w);
                    x--;
                end
            end
            while (x > 0 && y > 0)
            begin
                w.op = OP_EQUAL; w.li = 5'(x - 1); w.ri = 5'(y - 1); fwd.push_front(w);
                x--; y--;
            end
            while (x > 0)
            begin
                w.op = OP_DELETE; w.li = 5'(x - 1); w.ri = 5'd0; fwd.push_front(w);
                x--;
            end
            while (y > 0)
            begin
                w.op = OP_INSERT; w.li = 5'd0; w.ri = 5'(y - 1); fwd.push_front(w);
                y--;
            end
            for (int i = 0; i < fwd.size(); i++)
            begin
                w = fwd[i];
                w.lst = (i == fwd.size() - 1);
                pending.insert(pending.size(), w);
            end
        endfunction

        function void note_input(logic [1:0] kd, logic [31:0] kv);
            edit_word_t w;
            if (kd == KIND_LEFT)
            begin
                if (n_left < MAX_LINES) left_keys[n_left++] = kv;
                else dropped = 1;
            end
            else if (kd == KIND_RIGHT)
            begin
                if (n_right < MAX_LINES) right_keys[n_right++] = kv;
                else dropped = 1;
            end
            else if (kd == KIND_RUN)
            begin
                runs_seen++;
                if (n_left == 0 && n_right == 0)
                begin
                    w.op = OP_NONE; w.li = 0; w.ri = 0; w.lst = 1; w.ovf = dropped;
                    pending.insert(pending.size(), w);
                end
                else
                    predict_script();
                n_left = 0;
                n_right = 0;
                dropped = 0;
            end
        endfunction

        function void check_word(edit_word_t got);
            edit_word_t exp_w;
            words_seen++;
            if (pending.size() == 0)
            begin
                $error("unexpected word op=%0d l=%0d r=%0d", got.op, got.li, got.ri);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.op !== exp_w.op)
            begin
                $error("op: expected %0d actual %0d", exp_w.op, got.op); errors++;
            end
            if (got.li !== exp_w.li)
            begin
                $error("left_index: expected %0d actual %0d", exp_w.li, got.li); errors++;
            end
            if (got.ri !== exp_w.ri)
            begin
                $error("right_index: expected %0d actual %0d", exp_w.ri, got.ri); errors++;
            end
            if (got.lst !== exp_w.lst)
            begin
                $error("last: expected %0d actual %0d", exp_w.lst, got.lst); errors++;
            end
            if (got.ovf !== exp_w.ovf)
            begin
                $error("overflow: expected %0d actual %0d", exp_w.ovf, got.ovf); errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  kind = KIND_LEFT;
    logic [31:0] key = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [1:0]  op;
    logic [4:0]  left_index;
    logic [4:0]  right_index;
    logic        last;
    logic        overflow;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    edit_scoreboard board;

    myers_line_diff u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .key(key),
        .out_valid(out_valid), .out_stall(out_stall), .op(op),
        .left_index(left_index), .right_index(right_index),
        .last(last), .overflow(overflow)
    );

    always #1 clk = ~clk;

    // receiver side: random stall and checking of accepted words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_word('{op, left_index, right_index, last, overflow});
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_word(input logic [1:0] kd, input logic [31:0] kv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        kind <= kd;
        key <= kv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_input(kd, kv);
    endtask

    task automatic drop_valid();
        in_valid <= 0;
        @(posedge clk);
    endtask

    // keys from a small alphabet so lines often match; sometimes full range
    function automatic logic [31:0] pick_key();
        if ($urandom_range(9) == 0) return $urandom;
        return $urandom_range(3);
    endfunction

    task automatic send_case(input int nl, input int nr);
        logic [31:0] base[MAX_LINES];
        for (int i = 0; i < nl; i++)
        begin
            base[i] = pick_key();
            send_word(KIND_LEFT, base[i]);
        end
        for (int i = 0; i < nr; i++)
        begin
            // right side mostly an edited copy of the left side
            if (i < nl && $urandom_range(2) != 0) send_word(KIND_RIGHT, base[i]);
            else send_word(KIND_RIGHT, pick_key());
        end
        if ($urandom_range(19) == 0) send_word(2'd3, $urandom);
        send_word(KIND_RUN, $urandom);
    endtask

    task automatic run_phase(input int s_pct, input int r_pct, input int n_items);
        int sent;
        int nl, nr;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(4) == 0)
            begin
                nl = $urandom_range(MAX_LINES);
                nr = $urandom_range(MAX_LINES);
            end
            else
            begin
                nl = $urandom_range(8);
                nr = $urandom_range(8);
            end
            // keep the phase close to its word budget
            if (nl + nr + 1 > n_items - sent)
            begin
                nl = (n_items - sent) / 2;
                nr = n_items - sent - 1 - nl;
            end
            send_case(nl, nr);
            sent += nl + nr + 1;
        end
    endtask

    initial
    begin
        board = new();
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty run, one side only, extreme keys, overflow, kind 3
        send_word(KIND_RUN, 32'hFFFF_FFFF);
        send_word(KIND_LEFT, 32'h0000_0000);
        send_word(KIND_RUN, 0);
        send_word(KIND_RIGHT, 32'hFFFF_FFFF);
        send_word(KIND_RUN, 0);
        send_word(KIND_LEFT, 32'hFFFF_FFFF);
        send_word(KIND_LEFT, 32'h5555_5555);
        send_word(KIND_RIGHT, 32'hAAAA_AAAA);
        send_word(KIND_RIGHT, 32'hFFFF_FFFF);
        send_word(2'd3, 32'h1234_5678);
        send_word(KIND_RUN, 0);
        for (int i = 0; i < MAX_LINES + 1; i++) send_word(KIND_LEFT, i);
        for (int i = 0; i < MAX_LINES + 1; i++) send_word(KIND_RIGHT, MAX_LINES - i);
        send_word(KIND_RUN, 0);
        send_word(KIND_RIGHT, 7);
        send_word(KIND_RIGHT, 7);
        send_word(KIND_RUN, 0);
        drop_valid();

        run_phase(27, 53, 65);
        run_phase(53, 27, 65);
        run_phase(0, 0, 65);
        drop_valid();

        while (board.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d runs, %0d edit words checked",
                 board.runs_seen, board.words_seen);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS myers_line_diff");
        else
            $display("FAIL myers_line_diff");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL myers_line_diff");
        $finish;
    end
endmodule
